FILE: hw/rtl/lsb_first_bit_reader_assert.svh
// ----------------------------------------------------------------------------
// LSB-first bit reader assertion macros
// Shared concurrent assertion forms used by the bit reader top level.
// ----------------------------------------------------------------------------
`ifndef LSB_FIRST_BIT_READER_ASSERT_SVH
`define LSB_FIRST_BIT_READER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSBR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bit reader check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define LSBR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bit reader check failed one cycle later");

`endif

FILE: hw/rtl/lsbr_pkg.sv
// ----------------------------------------------------------------------------
// LSB-first bit reader package
// Operation and status codes and field widths of the bit reader.
// ----------------------------------------------------------------------------
package lsbr_pkg;

  localparam int FUNC_W   = 2;
  localparam int WORD_W   = 32;
  localparam int COUNT_W  = 6;
  localparam int STATUS_W = 2;
  localparam int BITS_W   = 14;
  localparam int ALIGN_W  = 3;
  localparam int LEN_W    = 11;
  localparam int SCR_W    = 64;
  localparam int SBITS_W  = 7;
  localparam int IDX_MIN_W = 9;

  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ALIGN = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BOUNDS  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PADDING = 2'd2;

  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

  function automatic logic [WORD_W-1:0] swap32(input logic [WORD_W-1:0] w);
    swap32 = {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

FILE: hw/rtl/lsb_first_bit_reader.sv
// A result sits in the output register in the cycle after its item is accepted.
// Throughput: one item per cycle unless the output stalls; the word memory is read
// one entry ahead at the next word index, with a forward of a load to that entry.
// Reset clears the pointers, the scratch and the bit count and sets the length
// register to 1024 bytes; the word memory keeps its contents and needs no clearing pass.
// ----------------------------------------------------------------------------
// LSB-first bit reader
// Unpacks 1 to 32 bit fields, least significant first, from a word memory.
// ----------------------------------------------------------------------------
module lsb_first_bit_reader #(
  parameter int STORE_WORDS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // load_word[31:0], bit_count[37:32], zero fill
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // value[31:0], status[33:32], bits_consumed[47:34],
                                      // bits_left[61:48], align_bits[64:62], zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  localparam int AW  = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int PW0 = $clog2(STORE_WORDS + 1);
  localparam int PW  = (PW0 > lsbr_pkg::IDX_MIN_W) ? PW0 : lsbr_pkg::IDX_MIN_W;

  logic [lsbr_pkg::WORD_W-1:0]  store [STORE_WORDS];
  logic [lsbr_pkg::WORD_W-1:0]  rd_data;
  logic [AW-1:0]                rd_addr;
  logic                         fwd_hit;
  logic [lsbr_pkg::WORD_W-1:0]  fwd_data;

  logic [PW-1:0]                load_pointer, load_pointer_next;
  logic [PW-1:0]                word_index, word_index_next;
  logic [lsbr_pkg::SCR_W-1:0]   scratch, scratch_next;
  logic [lsbr_pkg::SBITS_W-1:0] scratch_bits, scratch_bits_next;
  logic [lsbr_pkg::BITS_W-1:0]  bits_read, bits_read_next;
  logic [lsbr_pkg::LEN_W-1:0]   buffer_bytes;
  logic                         out_valid;
  logic [71:0]                  out_data;

  logic                         in_fire;
  logic [lsbr_pkg::FUNC_W-1:0]  func;
  logic [lsbr_pkg::WORD_W-1:0]  load_word;
  logic [lsbr_pkg::COUNT_W-1:0] bit_count;
  logic                         wr_en;
  logic                         store_has_room;
  logic                         do_take;
  logic [lsbr_pkg::COUNT_W-1:0] take_n;
  logic [2:0]                   rem;
  logic [lsbr_pkg::BITS_W-1:0]  limit;
  logic                         past_end;
  logic                         need_fetch;
  logic [lsbr_pkg::WORD_W-1:0]  word_cur;
  logic [lsbr_pkg::SCR_W-1:0]   filled;
  logic [lsbr_pkg::WORD_W:0]    mask;
  logic [lsbr_pkg::WORD_W-1:0]  take_value;
  logic [lsbr_pkg::WORD_W-1:0]  value;
  logic [lsbr_pkg::STATUS_W-1:0] status;
  logic [lsbr_pkg::BITS_W-1:0]  bits_left;
  logic [lsbr_pkg::ALIGN_W-1:0] align_bits;

  assign func      = s_axis_tuser;
  assign load_word = s_axis_tdata[31:0];
  assign bit_count = s_axis_tdata[37:32];

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  assign limit          = {buffer_bytes, 3'b000};
  assign rem            = bits_read[2:0];
  assign store_has_room = load_pointer < PW'(STORE_WORDS);

  // The entry at the word index, seen through a load to it in the last cycle.
  always_comb begin
    word_cur = fwd_hit ? fwd_data : rd_data;
    if (word_index >= PW'(STORE_WORDS)) begin
      word_cur = '0;
    end
  end

  always_comb begin
    take_n = bit_count;
    case (func)
      lsbr_pkg::FUNC_ALIGN: take_n = 6'(4'd8 - {1'b0, rem});
      default:              take_n = bit_count;
    endcase
  end

  assign past_end = ({1'b0, bits_read} + 15'(take_n)) > {1'b0, limit};

  always_comb begin
    wr_en   = 1'b0;
    do_take = 1'b0;
    status  = lsbr_pkg::ST_OK;
    case (func)
      lsbr_pkg::FUNC_LOAD: begin
        if (store_has_room) begin
          wr_en = in_fire;
        end else begin
          status = lsbr_pkg::ST_BOUNDS;
        end
      end
      lsbr_pkg::FUNC_READ: begin
        if (bit_count == '0) begin
          status = lsbr_pkg::ST_OK;
        end else if (bit_count > 6'd32 || past_end) begin
          status = lsbr_pkg::ST_BOUNDS;
        end else begin
          do_take = 1'b1;
        end
      end
      lsbr_pkg::FUNC_ALIGN: begin
        if (rem != 3'd0) begin
          if (past_end) begin
            status = lsbr_pkg::ST_BOUNDS;
          end else begin
            do_take = 1'b1;
          end
        end
      end
      default: status = lsbr_pkg::ST_OK;
    endcase
    if (do_take && take_value != '0 && func == lsbr_pkg::FUNC_ALIGN) begin
      status = lsbr_pkg::ST_PADDING;
    end
  end

  assign need_fetch = scratch_bits < {1'b0, take_n};

  always_comb begin
    filled = scratch;
    if (need_fetch) begin
      filled = scratch | ({32'd0, lsbr_pkg::swap32(word_cur)} << scratch_bits[4:0]);
    end
    mask       = (33'd1 << take_n) - 33'd1;
    take_value = filled[31:0] & mask[31:0];
  end

  always_comb begin
    load_pointer_next = load_pointer;
    word_index_next   = word_index;
    scratch_next      = scratch;
    scratch_bits_next = scratch_bits;
    bits_read_next    = bits_read;
    if (wr_en) begin
      load_pointer_next = load_pointer + PW'(1);
    end
    if (in_fire && do_take) begin
      scratch_next      = filled >> take_n;
      scratch_bits_next = (need_fetch ? scratch_bits + 7'd32 : scratch_bits) - 7'(take_n);
      bits_read_next    = bits_read + 14'(take_n);
      if (need_fetch) begin
        word_index_next = word_index + PW'(1);
      end
    end
  end

  assign value      = do_take ? take_value : '0;
  assign bits_left  = (limit > bits_read_next) ? limit - bits_read_next : '0;
  assign align_bits = 3'(3'd0 - bits_read_next[2:0]);
  assign rd_addr    = rst ? '0 : word_index_next[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[load_pointer[AW-1:0]] <= load_word;
    end
    rd_data  <= store[rd_addr];
    fwd_data <= load_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pointer <= '0;
      word_index   <= '0;
      scratch      <= '0;
      scratch_bits <= '0;
      bits_read    <= '0;
      buffer_bytes <= lsbr_pkg::LEN_RESET;
      fwd_hit      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      load_pointer <= load_pointer_next;
      word_index   <= word_index_next;
      scratch      <= scratch_next;
      scratch_bits <= scratch_bits_next;
      bits_read    <= bits_read_next;
      fwd_hit      <= wr_en && (load_pointer == word_index_next);
      if (cfg_valid && cfg_ready) begin
        buffer_bytes <= cfg_data;
      end
      if (in_fire) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= {7'd0, align_bits, bits_left, bits_read_next, status, value};
    end
  end

`include "lsb_first_bit_reader_assert.svh"

  `LSBR_ASSERT_SAME(a_bits_match_words, clk, rst, 1'b1, (15'(bits_read) + 15'(scratch_bits)) == (15'(word_index) << 5))
  `LSBR_ASSERT_SAME(a_count_monotonic, clk, rst, !$past(rst), bits_read >= $past(bits_read))
  `LSBR_ASSERT_NEXT(a_load_advances, clk, rst, wr_en, load_pointer == $past(load_pointer) + PW'(1))
  `LSBR_ASSERT_SAME(a_no_fetch_without_take, clk, rst, !(in_fire && do_take), word_index_next == word_index)

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bit reader testbench
// Drives load, read and align items into the LSB-first bit reader with random
// gaps and output stalls, predicts every result from a shadow of the word
// store and scratch, and checks each result field by field in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int STORE_WORDS = 256;
  localparam logic [lsbr_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;

  typedef struct packed {
    logic [lsbr_pkg::FUNC_W-1:0]  func;
    logic [lsbr_pkg::WORD_W-1:0]  word;
    logic [lsbr_pkg::COUNT_W-1:0] count;
  } bit_request_t;

  typedef struct packed {
    logic [lsbr_pkg::ALIGN_W-1:0]  align;
    logic [lsbr_pkg::BITS_W-1:0]   left;
    logic [lsbr_pkg::BITS_W-1:0]   consumed;
    logic [lsbr_pkg::STATUS_W-1:0] status;
    logic [lsbr_pkg::WORD_W-1:0]   value;
  } field_result_t;

  typedef struct {
    logic [lsbr_pkg::WORD_W-1:0] store [STORE_WORDS];
    int unsigned                 load_ptr;
    int unsigned                 word_idx;
    logic [lsbr_pkg::SCR_W-1:0]  scr;
    int unsigned                 scr_bits;
    int unsigned                 consumed;
    int unsigned                 len_bytes;
  } reader_state_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;

  lsb_first_bit_reader #(.STORE_WORDS(STORE_WORDS)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  bit_request_t  pending_items [$];
  field_result_t expected_fields [$];
  reader_state_t model_st;
  reader_state_t plan_st;

  bit in_taken;
  bit cfg_taken;
  bit quiet;
  bit long_hold_done;
  int gap_cnt;
  int hold_cnt;
  int n_accepted;
  int n_checked;
  int n_errors;
  int n_past_end;
  int n_padding;
  int n_settings;

  function automatic void clear_state(output reader_state_t st);
    for (int i = 0; i < STORE_WORDS; i++) st.store[i] = '0;
    st.load_ptr = 0;
    st.word_idx = 0;
    st.scr = '0;
    st.scr_bits = 0;
    st.consumed = 0;
    st.len_bytes = lsbr_pkg::LEN_RESET;
  endfunction

  function automatic field_result_t unpack_step(inout reader_state_t st,
                                                input logic [lsbr_pkg::FUNC_W-1:0] func,
                                                input logic [lsbr_pkg::WORD_W-1:0] word,
                                                input logic [lsbr_pkg::COUNT_W-1:0] count);
    field_result_t                 r;
    int unsigned                   lim;
    int unsigned                   rem;
    int unsigned                   n;
    logic [lsbr_pkg::WORD_W-1:0]   w;
    logic [lsbr_pkg::WORD_W-1:0]   v;
    logic [lsbr_pkg::STATUS_W-1:0] status;
    v = '0;
    status = lsbr_pkg::ST_OK;
    n = 0;
    lim = st.len_bytes * 8;
    case (func)
      lsbr_pkg::FUNC_LOAD: begin
        if (st.load_ptr < STORE_WORDS) begin
          st.store[st.load_ptr] = word;
          st.load_ptr++;
        end else begin
          status = lsbr_pkg::ST_BOUNDS;
        end
      end
      lsbr_pkg::FUNC_READ: begin
        if (count == 0) begin
          status = lsbr_pkg::ST_OK;
        end else if (int'(count) > lsbr_pkg::WORD_W || st.consumed + count > lim) begin
          status = lsbr_pkg::ST_BOUNDS;
        end else begin
          n = count;
        end
      end
      lsbr_pkg::FUNC_ALIGN: begin
        rem = st.consumed % 8;
        if (rem != 0) begin
          if (st.consumed + (8 - rem) > lim) status = lsbr_pkg::ST_BOUNDS;
          else n = 8 - rem;
        end
      end
      default: ;
    endcase
    if (n != 0) begin
      st.consumed += n;
      if (st.scr_bits < n) begin
        w = (st.word_idx < STORE_WORDS) ? st.store[st.word_idx] : '0;
        st.scr = st.scr | ({32'd0, w[7:0], w[15:8], w[23:16], w[31:24]} << st.scr_bits);
        st.scr_bits += lsbr_pkg::WORD_W;
        st.word_idx++;
      end
      v = lsbr_pkg::WORD_W'(st.scr & ((64'd1 << n) - 64'd1));
      st.scr = st.scr >> n;
      st.scr_bits -= n;
      if (func == lsbr_pkg::FUNC_ALIGN && v != 0) status = lsbr_pkg::ST_PADDING;
    end
    r.value = v;
    r.status = status;
    r.consumed = lsbr_pkg::BITS_W'(st.consumed);
    r.left = lsbr_pkg::BITS_W'((lim > st.consumed) ? lim - st.consumed : 0);
    r.align = lsbr_pkg::ALIGN_W'((8 - (st.consumed % 8)) % 8);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("tb: mismatch in %s after %0d results: got %0h, expected %0h",
             what, n_checked, got, want);
    n_errors++;
  endtask

  // Appends an item to the stimulus queue, first loading words when the item
  // would otherwise fetch a store entry that was never written; drops it if the store is full.
  task automatic queue_item(input logic [lsbr_pkg::FUNC_W-1:0] func,
                            input logic [lsbr_pkg::WORD_W-1:0] word,
                            input logic [lsbr_pkg::COUNT_W-1:0] count);
    reader_state_t trial;
    bit_request_t  req;
    forever begin
      trial = plan_st;
      void'(unpack_step(trial, func, word, count));
      if (trial.word_idx == plan_st.word_idx || plan_st.word_idx < plan_st.load_ptr) break;
      if (plan_st.load_ptr >= STORE_WORDS) return;
      req = '{func: lsbr_pkg::FUNC_LOAD, word: $urandom,
              count: lsbr_pkg::COUNT_W'($urandom)};
      void'(unpack_step(plan_st, req.func, req.word, req.count));
      pending_items.push_back(req);
    end
    plan_st = trial;
    req = '{func: func, word: word, count: count};
    pending_items.push_back(req);
  endtask

  task automatic queue_random(input int items);
    int pick;
    logic [lsbr_pkg::COUNT_W-1:0] cnt;
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) < 3) cnt = lsbr_pkg::COUNT_W'($urandom_range(1, 8));
      else if ($urandom_range(0, 9) < 3) cnt = lsbr_pkg::COUNT_W'(32);
      else cnt = lsbr_pkg::COUNT_W'($urandom_range(1, 32));
      if (pick < 35) begin
        queue_item(lsbr_pkg::FUNC_LOAD, $urandom, lsbr_pkg::COUNT_W'($urandom));
      end else if (pick < 84) begin
        queue_item(lsbr_pkg::FUNC_READ, $urandom, cnt);
      end else if (pick < 93) begin
        queue_item(lsbr_pkg::FUNC_ALIGN, $urandom, lsbr_pkg::COUNT_W'($urandom));
      end else if (pick < 96) begin
        queue_item(FUNC_SPARE, $urandom, lsbr_pkg::COUNT_W'($urandom));
      end else if (pick < 98) begin
        queue_item(lsbr_pkg::FUNC_READ, $urandom, lsbr_pkg::COUNT_W'(0));
      end else begin
        queue_item(lsbr_pkg::FUNC_READ, $urandom, lsbr_pkg::COUNT_W'($urandom_range(33, 63)));
      end
    end
  endtask

  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (pending_items.size() != 0 || s_axis_tvalid || expected_fields.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_length(input int unsigned bytes);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= lsbr_pkg::LEN_W'(bytes);
    do begin
      @(posedge clk);
      #1;
    end while (!cfg_taken);
    model_st.len_bytes = bytes;
    plan_st.len_bytes = bytes;
    n_settings++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Input side: holds an item until it is taken, idles in bursts between items.
  always @(negedge clk) begin
    if (!rst && !(s_axis_tvalid && !in_taken)) begin
      if (gap_cnt > 0) begin
        gap_cnt--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        if (!quiet && $urandom_range(0, 9) == 0) begin
          gap_cnt = $urandom_range(1, 19) - 1;
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= pending_items[0].func;
          s_axis_tdata <= {2'b00, pending_items[0].count, pending_items[0].word};
          void'(pending_items.pop_front());
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output side: random stalls, plus one long hold-off to back the block up.
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else if (!long_hold_done && n_accepted >= 50) begin
      long_hold_done = 1'b1;
      hold_cnt = 79;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      hold_cnt = $urandom_range(1, 19) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    field_result_t want;
    field_result_t got;
    if (rst) begin
      in_taken = 1'b0;
      cfg_taken = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[64:0];
        if (expected_fields.size() == 0) begin
          report_mismatch("unexpected result value", got.value, '0);
        end else begin
          want = expected_fields.pop_front();
          if (got.value !== want.value) report_mismatch("value", got.value, want.value);
          if (got.status !== want.status) report_mismatch("status", got.status, want.status);
          if (got.consumed !== want.consumed)
            report_mismatch("bits_consumed", got.consumed, want.consumed);
          if (got.left !== want.left) report_mismatch("bits_left", got.left, want.left);
          if (got.align !== want.align) report_mismatch("align_bits", got.align, want.align);
          n_checked++;
        end
      end
      cfg_taken = cfg_valid && cfg_ready;
      in_taken = s_axis_tvalid && s_axis_tready;
      if (in_taken) begin
        want = unpack_step(model_st, s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[37:32]);
        expected_fields.push_back(want);
        n_accepted++;
        if (want.status == lsbr_pkg::ST_BOUNDS) n_past_end++;
        if (want.status == lsbr_pkg::ST_PADDING) n_padding++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    clear_state(model_st);
    clear_state(plan_st);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Items before any word is loaded, bad counts and the unused function.
    queue_item(lsbr_pkg::FUNC_ALIGN, '0, '0);
    queue_item(lsbr_pkg::FUNC_READ, 32'hFFFF_FFFF, lsbr_pkg::COUNT_W'(0));
    queue_item(lsbr_pkg::FUNC_READ, '0, lsbr_pkg::COUNT_W'(33));
    queue_item(lsbr_pkg::FUNC_READ, 32'hFFFF_FFFF, lsbr_pkg::COUNT_W'(63));
    queue_item(FUNC_SPARE, 32'hFFFF_FFFF, lsbr_pkg::COUNT_W'(63));
    queue_item(lsbr_pkg::FUNC_LOAD, 32'hFFFF_FFFF, lsbr_pkg::COUNT_W'(63));
    queue_item(lsbr_pkg::FUNC_LOAD, 32'h0000_0000, lsbr_pkg::COUNT_W'(0));
    queue_item(lsbr_pkg::FUNC_LOAD, 32'h1234_5678, lsbr_pkg::COUNT_W'(5));
    queue_item(lsbr_pkg::FUNC_LOAD, 32'h8000_0001, lsbr_pkg::COUNT_W'(32));
    queue_item(lsbr_pkg::FUNC_LOAD, 32'hA5C3_0F96, lsbr_pkg::COUNT_W'(1));
    queue_item(lsbr_pkg::FUNC_READ, '0, lsbr_pkg::COUNT_W'(1));
    queue_item(lsbr_pkg::FUNC_READ, '0, lsbr_pkg::COUNT_W'(32));
    queue_item(lsbr_pkg::FUNC_READ, '0, lsbr_pkg::COUNT_W'(3));
    queue_item(lsbr_pkg::FUNC_ALIGN, '0, '0);
    queue_item(lsbr_pkg::FUNC_ALIGN, '0, '0);
    queue_item(lsbr_pkg::FUNC_READ, '0, lsbr_pkg::COUNT_W'(32));
    queue_item(lsbr_pkg::FUNC_READ, '0, lsbr_pkg::COUNT_W'(7));
    queue_item(lsbr_pkg::FUNC_ALIGN, '0, '0);
    queue_item(lsbr_pkg::FUNC_READ, '0, lsbr_pkg::COUNT_W'(31));
    queue_item(lsbr_pkg::FUNC_READ, '0, lsbr_pkg::COUNT_W'(17));
    queue_item(lsbr_pkg::FUNC_READ, '0, lsbr_pkg::COUNT_W'(3));

    // Length shrunk below what has already been read.
    set_length(4);
    queue_item(lsbr_pkg::FUNC_READ, '0, lsbr_pkg::COUNT_W'(1));
    queue_item(lsbr_pkg::FUNC_ALIGN, '0, '0);
    queue_item(lsbr_pkg::FUNC_READ, '0, lsbr_pkg::COUNT_W'(0));

    set_length(1024);
    queue_random(60);

    // A length a little past the current position, so reads run into the end.
    set_length(((plan_st.consumed / 8 + 16 + $urandom_range(0, 8)) / 4) * 4);
    queue_random(30);

    set_length(4 * $urandom_range(plan_st.consumed / 32 + 40, 256));
    queue_random(30);

    set_length(1024);
    wait_idle();
    quiet = 1'b1;
    while (plan_st.load_ptr < STORE_WORDS + 3) begin
      queue_item(lsbr_pkg::FUNC_LOAD, $urandom, lsbr_pkg::COUNT_W'($urandom));
      if (plan_st.load_ptr >= STORE_WORDS) plan_st.load_ptr++;
    end
    plan_st.load_ptr = STORE_WORDS;
    queue_random(40);

    wait_idle();
    repeat (4) @(posedge clk);
    $display("tb: %0d items accepted and %0d results checked over %0d length settings",
             n_accepted, n_checked, n_settings);
    $display("tb: %0d bounds or full-store results, %0d nonzero padding results, %0d bits read",
             n_past_end, n_padding, model_st.consumed);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
